// ===== sv/clif_pkg.sv =====
// Shared constants, codes and helpers for the conductance LIF neuron update block.
package clif_pkg;

	localparam int NEURON_COUNT_DEF = 16384;

	localparam int IDX_W      = 14;
	localparam int WEIGHT_W   = 20;
	localparam int G_W        = 20;
	localparam int P_W        = 20;
	localparam int V_W        = 16;
	localparam int T_W        = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;
	localparam int FACTOR_W   = 17;
	localparam int MUL_W      = 21;
	localparam int PROD_W     = 2 * MUL_W;
	localparam int ACC_W      = PROD_W + 2;
	localparam int RAM_W      = G_W + V_W + P_W + T_W;

	localparam logic OP_ACCUMULATE = 1'b0;
	localparam logic OP_STEP       = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_COND_DECAY,
		CFG_THRESH_DECAY,
		CFG_VOLTAGE_LEAK,
		CFG_BASE_THRESHOLD,
		CFG_RAISED_THRESHOLD
	} cfg_reg_t;

	localparam logic signed [V_W-1:0] V_REST       = -16'sd17920;
	localparam logic signed [V_W-1:0] V_RESET      = -16'sd20480;
	localparam logic signed [V_W-1:0] V_REVERSAL   = 16'sd512;
	localparam logic signed [V_W-1:0] MOSSY_DRIVE  = 16'sd7680;
	localparam logic signed [T_W-1:0] T_RESET      = -16'sd14080;
	localparam logic signed [T_W-1:0] RAISED_RESET = -16'sd10240;
	localparam logic [G_W-1:0]        G_MAX        = 20'hFFFFF;
	localparam logic signed [P_W:0]   P_MAX        = 21'sd524287;
	localparam logic signed [P_W:0]   P_MIN        = -21'sd524288;
	localparam logic signed [MUL_W-1:0] Q16_ONE    = 21'sd65536;

	// Saturate a wide signed value to the signed 16 bit range.
	function automatic logic signed [15:0] sat16(input logic signed [29:0] x);
		logic signed [15:0] r;
		if (x > 30'sd32767) begin
			r = 16'sh7FFF;
		end else if (x < -30'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = x[15:0];
		end
		return r;
	endfunction

endpackage

// ===== sv/clif_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module clif_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/conductance_lif_neuron_update.sv =====
// Top level of the conductance based LIF neuron array update block.
//
// Usage: an item is taken on a rising edge with start high and busy low. After reset the
// block sweeps the neuron memory once to load rest values, one neuron per cycle, with busy
// high during the sweep; configuration writes are taken during the sweep. An out of range
// index returns its result word in the next cycle, an accumulate passes S_READ and S_LOAD,
// and a step passes S_READ, S_LOAD, S_M1 to S_M7 and S_FIN: all neuron state sits in one
// memory word that is read once and written once, and the five products of a step go one
// per cycle through a single shared 21 by 21 bit multiplier. The result word is shown for
// exactly one cycle with done high and cannot be held off; busy is already low in that
// cycle, so a new item may be started at the same edge that takes the result.
module conductance_lif_neuron_update import clif_pkg::*; #(
	parameter int NEURON_COUNT = NEURON_COUNT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         operation,
	input  logic [IDX_W-1:0]             neuron_index,
	input  logic signed [WEIGHT_W-1:0]   weight,
	input  logic                         is_mossy,
	input  logic                         mossy_pulse,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data,
	output logic                         done,
	output logic [IDX_W-1:0]             index_out,
	output logic                         fired,
	output logic signed [V_W-1:0]        voltage_out
);

	localparam int AW = $clog2(NEURON_COUNT > 1 ? NEURON_COUNT : 2);

	localparam int G_LSB = V_W + P_W + T_W;
	localparam int V_LSB = P_W + T_W;
	localparam int P_LSB = T_W;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_READ, S_LOAD,
		S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_FIN
	} state_t;

	state_t state_q;
	logic [AW-1:0] clr_q;
	logic done_q, fired_q;
	logic [IDX_W-1:0] index_out_q;
	logic signed [V_W-1:0] voltage_out_q;

	logic [FACTOR_W-1:0] cond_decay_q, thresh_decay_q, voltage_leak_q;
	logic signed [T_W-1:0] base_q, raised_q;

	logic op_q, mossy_q, pulse_q;
	logic [IDX_W-1:0] idx_q;
	logic [AW-1:0] addr_q;
	logic signed [WEIGHT_W-1:0] weight_q;
	logic [G_W-1:0] g_q;
	logic signed [P_W-1:0] p_q;
	logic signed [V_W-1:0] v_q;
	logic signed [T_W-1:0] t_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0] acc_q;

	logic ram_we;
	logic [AW-1:0] ram_waddr;
	logic [RAM_W-1:0] ram_wdata, ram_rdata;

	logic [G_W-1:0] rd_g;
	logic signed [V_W-1:0] rd_v;
	logic signed [P_W-1:0] rd_p;
	logic signed [T_W-1:0] rd_t;

	logic accept, in_range, spike;
	logic signed [P_W:0] psum;
	logic signed [P_W-1:0] p_acc;
	logic signed [MUL_W-1:0] mul_a, mul_b;
	logic signed [16:0] v_rest_term, v_base_term, v_rev_term, t_base_term;
	logic signed [ACC_W-1:0] prod_ext;
	logic signed [28:0] gsum;
	logic [G_W-1:0] g_new;
	logic signed [29:0] tsum, vsum, drive;
	logic signed [V_W-1:0] v_fin;
	logic signed [T_W-1:0] t_fin;

	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign in_range = 32'(neuron_index) < NEURON_COUNT;

	assign done        = done_q;
	assign index_out   = index_out_q;
	assign fired       = fired_q;
	assign voltage_out = voltage_out_q;

	assign rd_g = ram_rdata[G_LSB +: G_W];
	assign rd_v = ram_rdata[V_LSB +: V_W];
	assign rd_p = ram_rdata[P_LSB +: P_W];
	assign rd_t = ram_rdata[0 +: T_W];

	// Saturating add of the weight to the pending input read from memory.
	assign psum = $signed({rd_p[P_W-1], rd_p}) + $signed({weight_q[WEIGHT_W-1], weight_q});
	always_comb begin
		priority if (psum > P_MAX) begin
			p_acc = P_MAX[P_W-1:0];
		end else if (psum < P_MIN) begin
			p_acc = P_MIN[P_W-1:0];
		end else begin
			p_acc = psum[P_W-1:0];
		end
	end

	assign v_rest_term = $signed({v_q[V_W-1], v_q}) - $signed({V_REST[V_W-1], V_REST});
	assign v_base_term = $signed({v_q[V_W-1], v_q}) + $signed({base_q[T_W-1], base_q});
	assign v_rev_term  = $signed({v_q[V_W-1], v_q}) - $signed({V_REVERSAL[V_W-1], V_REVERSAL});
	assign t_base_term = $signed({t_q[T_W-1], t_q}) - $signed({base_q[T_W-1], base_q});

	// Operand selection for the shared multiplier, one product per sequencer step.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_M1: begin
				mul_a = $signed({p_q[P_W-1], p_q});
				mul_b = Q16_ONE - $signed({1'b0, g_q});
			end
			S_M2: begin
				mul_a = $signed({4'd0, cond_decay_q});
				mul_b = $signed({1'b0, g_q});
			end
			S_M3: begin
				mul_a = $signed({4'd0, voltage_leak_q});
				mul_b = mossy_q ? $signed({{4{v_base_term[16]}}, v_base_term})
				                : $signed({{4{v_rest_term[16]}}, v_rest_term});
			end
			S_M4: begin
				mul_a = $signed({{4{t_base_term[16]}}, t_base_term});
				mul_b = $signed({4'd0, thresh_decay_q});
			end
			S_M5: begin
				mul_a = $signed({1'b0, g_q});
				mul_b = $signed({{4{v_rev_term[16]}}, v_rev_term});
			end
			default: begin
			end
		endcase
	end

	assign prod_ext = $signed({{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q});

	// Conductance update: the accumulator holds the numerator, floor by the arithmetic shift.
	assign gsum = $signed({9'd0, g_q}) + $signed({acc_q[ACC_W-1], acc_q[ACC_W-1:16]});
	always_comb begin
		priority if (gsum < 29'sd0) begin
			g_new = '0;
		end else if (gsum > $signed({9'd0, G_MAX})) begin
			g_new = G_MAX;
		end else begin
			g_new = gsum[G_W-1:0];
		end
	end

	assign tsum  = $signed({{14{t_q[T_W-1]}}, t_q})
	             - $signed({{4{prod_q[PROD_W-1]}}, prod_q[PROD_W-1:16]});
	assign drive = (mossy_q && pulse_q) ? 30'(MOSSY_DRIVE) : 30'sd0;
	assign vsum  = $signed({{14{v_q[V_W-1]}}, v_q})
	             + $signed({{2{acc_q[ACC_W-1]}}, acc_q[ACC_W-1:16]}) + drive;

	assign spike = (v_q > t_q);
	assign v_fin = spike ? V_RESET : v_q;
	assign t_fin = spike ? raised_q : t_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = {rd_g, rd_v, p_acc, rd_t};
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = {{G_W{1'b0}}, V_REST, {P_W{1'b0}}, T_RESET};
			end
			S_LOAD: begin
				ram_we = (op_q == OP_ACCUMULATE);
			end
			S_FIN: begin
				ram_we    = 1'b1;
				ram_wdata = {g_q, v_fin, {P_W{1'b0}}, t_fin};
			end
			default: begin
			end
		endcase
	end

	clif_ram #(
		.WIDTH(RAM_W),
		.DEPTH(NEURON_COUNT)
	) u_state_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(addr_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			clr_q          <= '0;
			done_q         <= 1'b0;
			fired_q        <= 1'b0;
			index_out_q    <= '0;
			voltage_out_q  <= '0;
			cond_decay_q   <= '0;
			thresh_decay_q <= '0;
			voltage_leak_q <= '0;
			base_q         <= T_RESET;
			raised_q       <= RAISED_RESET;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					CFG_COND_DECAY:       cond_decay_q   <= cfg_data;
					CFG_THRESH_DECAY:     thresh_decay_q <= cfg_data;
					CFG_VOLTAGE_LEAK:     voltage_leak_q <= cfg_data;
					CFG_BASE_THRESHOLD:   base_q         <= cfg_data[T_W-1:0];
					CFG_RAISED_THRESHOLD: raised_q       <= cfg_data[T_W-1:0];
					default: begin
					end
				endcase
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(NEURON_COUNT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						if (in_range) begin
							state_q <= S_READ;
						end else begin
							done_q        <= 1'b1;
							index_out_q   <= neuron_index;
							fired_q       <= 1'b0;
							voltage_out_q <= '0;
						end
					end
				end
				S_READ: state_q <= S_LOAD;
				S_LOAD: begin
					if (op_q == OP_ACCUMULATE) begin
						done_q        <= 1'b1;
						index_out_q   <= idx_q;
						fired_q       <= 1'b0;
						voltage_out_q <= rd_v;
						state_q       <= S_IDLE;
					end else begin
						state_q <= S_M1;
					end
				end
				S_M1: state_q <= S_M2;
				S_M2: state_q <= S_M3;
				S_M3: state_q <= S_M4;
				S_M4: state_q <= S_M5;
				S_M5: state_q <= S_M6;
				S_M6: state_q <= S_M7;
				S_M7: state_q <= S_FIN;
				S_FIN: begin
					done_q        <= 1'b1;
					index_out_q   <= idx_q;
					fired_q       <= spike;
					voltage_out_q <= v_fin;
					state_q       <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers; the product register is loaded every cycle.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					op_q     <= operation;
					idx_q    <= neuron_index;
					addr_q   <= AW'(neuron_index);
					weight_q <= weight;
					mossy_q  <= is_mossy;
					pulse_q  <= mossy_pulse;
				end
			end
			S_LOAD: begin
				g_q <= rd_g;
				p_q <= rd_p;
				v_q <= rd_v;
				t_q <= rd_t;
			end
			S_M2: acc_q <= prod_ext;
			S_M3: acc_q <= acc_q - prod_ext;
			S_M4: begin
				g_q   <= g_new;
				acc_q <= '0 - prod_ext;
			end
			S_M5: t_q <= sat16(tsum);
			S_M6: begin
				if (!mossy_q) begin
					acc_q <= acc_q - prod_ext;
				end
			end
			S_M7: v_q <= sat16(vsum);
			default: begin
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result word shown while the sequencer is busy");

	a_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_range) |=> (busy && !done))
		else $error("in range item did not start the sequencer");

	a_oor_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !in_range) |=> (done && !fired && voltage_out == '0))
		else $error("out of range item gave a wrong result word");

	a_ram_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_CLEAR || state_q == S_LOAD || state_q == S_FIN))
		else $error("neuron memory written outside clear, accumulate or writeback");

	a_fire_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(done && fired) |-> (voltage_out == V_RESET))
		else $error("spike reported without reset voltage");
`endif

endmodule
